/* src/halfspace_triangle_raster_zbuf_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the triangle raster unit
// Shared forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef HALFSPACE_TRIANGLE_RASTER_ZBUF_UNIT_DEFINES_SVH
`define HALFSPACE_TRIANGLE_RASTER_ZBUF_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTRZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTRZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/htrz_pkg.sv */
// ---------------------------------------------------------------------------
// htrz_pkg
// Types, widths and codes shared by the triangle raster unit.
// ---------------------------------------------------------------------------
`default_nettype none

package htrz_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [3:0] CFG_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_HEIGHT = 4'd1;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Edge function values, depth numerator and magnitude of the area.
  localparam int EDGE_W = 40;
  localparam int AREA_W = 36;
  localparam int QUOT_W = 17;
  localparam int NUM_W  = AREA_W + QUOT_W;

  typedef logic signed [MUL_AW-1:0] mul_a_t;
  typedef logic signed [MUL_BW-1:0] mul_b_t;
  typedef logic signed [MUL_PW-1:0] mul_p_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [13:0]       coord_t;

endpackage

`default_nettype wire

/* src/halfspace_triangle_raster_zbuf_unit.sv */
// ---------------------------------------------------------------------------
// halfspace_triangle_raster_zbuf_unit
// Edge function triangle rasterizer with a color and depth buffer.
// ---------------------------------------------------------------------------
// Usage: an input word carries an action (draw, read pixel, write pixel),
// three Q4 vertices with depths and a color. Each accepted word yields one
// result word on the output channel. The configuration channel sets the
// screen width and height and is always ready.
// After reset a clearing pass sweeps both stores, one address a cycle, over
// all MAX_WIDTH * MAX_HEIGHT addresses; in_ready stays low until it ends.
// The unit works on one word at a time and is not ready meanwhile.
// A read or write forms its address on the shared multiplier; a write then
// stores the pixel and a read registers the stored color and depth. A draw
// runs a setup of nine products through the one shared multiplier, then
// walks each pixel of the clamped bounding box; a covered pixel adds three
// products and a 17-step restoring divide before its depth test.
// Results sit in an output register: a stalled receiver does not stop the
// next word from being accepted, but its result waits until the register
// frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module halfspace_triangle_raster_zbuf_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] v0_x,
  input  wire logic [15:0] v0_y,
  input  wire logic [15:0] v0_z,
  input  wire logic [15:0] v1_x,
  input  wire logic [15:0] v1_y,
  input  wire logic [15:0] v1_z,
  input  wire logic [15:0] v2_x,
  input  wire logic [15:0] v2_y,
  input  wire logic [15:0] v2_z,
  input  wire logic [31:0] fill_color,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      pixels_written,
  output logic [31:0]      read_color,
  output logic [15:0]      read_depth,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import htrz_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_PIX   = 4'd3;
  localparam logic [3:0] S_ADV   = 4'd4;
  localparam logic [3:0] S_Z     = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ZCMP  = 4'd7;
  localparam logic [3:0] S_ADDR  = 4'd8;
  localparam logic [3:0] S_ADDR2 = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_RD2   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]  state;
  logic [8:0]  scr_w;
  logic [8:0]  scr_h;
  logic [AW-1:0] clr_addr;

  // Latched input word.
  logic [1:0]         act;
  logic signed [15:0] x0, y0, x1, y1, x2, y2;
  logic [15:0]        z0, z1, z2;
  logic [31:0]        color;

  // Box, walk position and edge values.
  coord_t      minx, maxx, miny, maxy, px, py;
  logic        box_empty;
  logic        rw_ok;
  logic [3:0]  step;
  logic [4:0]  div_cnt;
  edge_t       r0, r1, r2, c0, c1, c2, area;
  logic [AREA_W-1:0] aarea;
  logic [AW-1:0] row_base;
  logic [AW-1:0] addr;
  logic [NUM_W-1:0]  num;
  logic [AREA_W-1:0] rem;
  logic [QUOT_W-1:0] quo;
  logic [16:0] cnt;
  logic [31:0] res_color;
  logic [15:0] res_depth;

  // Effective screen size: zero reads as one, larger saturates to the built size.
  logic [12:0] weff, heff;
  always_comb begin
    weff = {4'b0, scr_w};
    if (scr_w == 9'd0) begin
      weff = 13'd1;
    end else if ({4'b0, scr_w} > 13'(MAX_WIDTH)) begin
      weff = 13'(MAX_WIDTH);
    end
    heff = {4'b0, scr_h};
    if (scr_h == 9'd0) begin
      heff = 13'd1;
    end else if ({4'b0, scr_h} > 13'(MAX_HEIGHT)) begin
      heff = 13'(MAX_HEIGHT);
    end
  end

  // Bounding box of the incoming triangle, floored, ceiled and clamped.
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [16:0] cx, cy;
  coord_t bminx, bmaxx, bminy, bmaxy, wlim, hlim;
  logic   in_rw_ok;
  always_comb begin
    mnx = $signed(v0_x);
    if ($signed(v1_x) < mnx) mnx = $signed(v1_x);
    if ($signed(v2_x) < mnx) mnx = $signed(v2_x);
    mxx = $signed(v0_x);
    if ($signed(v1_x) > mxx) mxx = $signed(v1_x);
    if ($signed(v2_x) > mxx) mxx = $signed(v2_x);
    mny = $signed(v0_y);
    if ($signed(v1_y) < mny) mny = $signed(v1_y);
    if ($signed(v2_y) < mny) mny = $signed(v2_y);
    mxy = $signed(v0_y);
    if ($signed(v1_y) > mxy) mxy = $signed(v1_y);
    if ($signed(v2_y) > mxy) mxy = $signed(v2_y);
    cx = (17'(mxx) + 17'sd15) >>> 4;
    cy = (17'(mxy) + 17'sd15) >>> 4;
    bminx = 14'(mnx >>> 4);
    bmaxx = 14'(cx);
    bminy = 14'(mny >>> 4);
    bmaxy = 14'(cy);
    wlim = $signed({1'b0, weff}) - 14'sd1;
    hlim = $signed({1'b0, heff}) - 14'sd1;
    if (bminx < 14'sd0) bminx = 14'sd0;
    if (bminy < 14'sd0) bminy = 14'sd0;
    if (bmaxx > wlim) bmaxx = wlim;
    if (bmaxy > hlim) bmaxy = hlim;
    in_rw_ok = ($signed(v0_x) >= 16'sd0) && (17'($signed(v0_x)) < $signed({4'b0, weff}))
            && ($signed(v0_y) >= 16'sd0) && (17'($signed(v0_y)) < $signed({4'b0, heff}));
  end

  // Operand selection for the shared multiplier.
  logic signed [17:0] px0, py0;
  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t prod;
  edge_t  cabs;
  always_comb begin
    px0 = 18'({minx, 4'b1000});
    py0 = 18'({miny, 4'b1000});
    mul_a = '0;
    mul_b = '0;
    cabs  = '0;
    case (state)
      S_SETUP: begin
        case (step)
          4'd0: begin
            mul_a = MUL_AW'(px0 - 18'(x1));
            mul_b = 18'(y2) - 18'(y1);
          end
          4'd1: begin
            mul_a = MUL_AW'(py0 - 18'(y1));
            mul_b = 18'(x2) - 18'(x1);
          end
          4'd2: begin
            mul_a = MUL_AW'(px0 - 18'(x2));
            mul_b = 18'(y0) - 18'(y2);
          end
          4'd3: begin
            mul_a = MUL_AW'(py0 - 18'(y2));
            mul_b = 18'(x0) - 18'(x2);
          end
          4'd4: begin
            mul_a = MUL_AW'(px0 - 18'(x0));
            mul_b = 18'(y1) - 18'(y0);
          end
          4'd5: begin
            mul_a = MUL_AW'(py0 - 18'(y0));
            mul_b = 18'(x1) - 18'(x0);
          end
          4'd6: begin
            mul_a = MUL_AW'(18'(x2) - 18'(x0));
            mul_b = 18'(y1) - 18'(y0);
          end
          4'd7: begin
            mul_a = MUL_AW'(18'(y2) - 18'(y0));
            mul_b = 18'(x1) - 18'(x0);
          end
          4'd8: begin
            mul_a = MUL_AW'(miny);
            mul_b = $signed({5'b0, weff});
          end
          default: begin
            mul_a = '0;
          end
        endcase
      end
      S_Z: begin
        case (step)
          4'd0: begin
            cabs  = c0[EDGE_W-1] ? -c0 : c0;
            mul_b = $signed({2'b0, z0});
          end
          4'd1: begin
            cabs  = c1[EDGE_W-1] ? -c1 : c1;
            mul_b = $signed({2'b0, z1});
          end
          4'd2: begin
            cabs  = c2[EDGE_W-1] ? -c2 : c2;
            mul_b = $signed({2'b0, z2});
          end
          default: begin
            cabs = '0;
          end
        endcase
        mul_a = MUL_AW'(cabs);
      end
      S_ADDR: begin
        mul_a = MUL_AW'(y0);
        mul_b = $signed({5'b0, weff});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  htrz_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Pixel coverage: all edge values of one sign, either winding.
  logic covered;
  always_comb begin
    covered = (!c0[EDGE_W-1] && !c1[EDGE_W-1] && !c2[EDGE_W-1])
           || ((c0[EDGE_W-1] || c0 == '0) && (c1[EDGE_W-1] || c1 == '0)
               && (c2[EDGE_W-1] || c2 == '0));
  end

  // Edge steps for one pixel right and one row down.
  edge_t dx0, dx1, dx2, dy0, dy1, dy2;
  always_comb begin
    dx0 = EDGE_W'(18'(y2) - 18'(y1)) <<< 4;
    dx1 = EDGE_W'(18'(y0) - 18'(y2)) <<< 4;
    dx2 = EDGE_W'(18'(y1) - 18'(y0)) <<< 4;
    dy0 = EDGE_W'(18'(x1) - 18'(x2)) <<< 4;
    dy1 = EDGE_W'(18'(x2) - 18'(x0)) <<< 4;
    dy2 = EDGE_W'(18'(x0) - 18'(x1)) <<< 4;
  end

  // Depth numerator complete and one restoring divide step.
  logic [NUM_W-1:0]  num_fin;
  logic [AREA_W:0]   dtrial;
  logic              dbit;
  logic [15:0]       zsat;
  always_comb begin
    num_fin = num + prod[NUM_W-1:0];
    dtrial  = {rem, quo[QUOT_W-1]};
    dbit    = dtrial >= {1'b0, aarea};
    zsat    = quo[16] ? 16'hFFFF : quo[15:0];
  end

  // Store ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   col_wdata;
  logic [15:0]   dep_wdata;
  logic [31:0]   col_rdata;
  logic [15:0]   dep_rdata;
  logic          z_pass;
  always_comb begin
    z_pass    = zsat < dep_rdata;
    ram_we    = 1'b0;
    ram_waddr = addr;
    col_wdata = color;
    dep_wdata = z0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        col_wdata = '0;
        dep_wdata = 16'hFFFF;
      end
      S_RD: begin
        ram_we = act == ACT_WRITE;
      end
      S_ZCMP: begin
        ram_we    = z_pass;
        dep_wdata = zsat;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  htrz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (col_wdata),
    .raddr (addr),
    .rdata (col_rdata)
  );

  htrz_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (dep_wdata),
    .raddr (addr),
    .rdata (dep_rdata)
  );

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= 9'd256;
      scr_h <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        scr_w <= cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        scr_h <= cfg_data;
      end
    end
  end

  // Payload registers of the word in flight.
  logic [31:0] addr_wide;
  always_comb begin
    addr_wide = prod[31:0] + {16'b0, x0};
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act       <= action;
      x0        <= $signed(v0_x);
      y0        <= $signed(v0_y);
      z0        <= v0_z;
      x1        <= $signed(v1_x);
      y1        <= $signed(v1_y);
      z1        <= v1_z;
      x2        <= $signed(v2_x);
      y2        <= $signed(v2_y);
      z2        <= v2_z;
      color     <= fill_color;
      minx      <= bminx;
      maxx      <= bmaxx;
      miny      <= bminy;
      maxy      <= bmaxy;
      box_empty <= (bminx > bmaxx) || (bminy > bmaxy);
      rw_ok     <= in_rw_ok;
      cnt       <= '0;
      res_color <= '0;
      res_depth <= '0;
      step      <= '0;
    end
    case (state)
      S_SETUP: begin
        step <= step + 4'd1;
        case (step)
          4'd1: r0 <= EDGE_W'(prod);
          4'd2: r0 <= r0 - EDGE_W'(prod);
          4'd3: r1 <= EDGE_W'(prod);
          4'd4: r1 <= r1 - EDGE_W'(prod);
          4'd5: r2 <= EDGE_W'(prod);
          4'd6: r2 <= r2 - EDGE_W'(prod);
          4'd7: area <= EDGE_W'(prod);
          4'd8: area <= area - EDGE_W'(prod);
          4'd9: begin
            row_base <= AW'(prod);
            aarea    <= AREA_W'(area[EDGE_W-1] ? -area : area);
            c0 <= r0;
            c1 <= r1;
            c2 <= r2;
            px <= minx;
            py <= miny;
          end
          default: begin
            area <= area;
          end
        endcase
      end
      S_PIX: begin
        step <= '0;
        addr <= row_base + AW'(px);
        num  <= NUM_W'(aarea >> 1);
      end
      S_Z: begin
        step <= step + 4'd1;
        if (step != 4'd0) begin
          num <= num_fin;
        end
        if (step == 4'd3) begin
          rem     <= num_fin[NUM_W-1:QUOT_W];
          quo     <= num_fin[QUOT_W-1:0];
          div_cnt <= '0;
        end
      end
      S_DIV: begin
        div_cnt <= div_cnt + 5'd1;
        rem     <= dbit ? AREA_W'(dtrial - {1'b0, aarea}) : dtrial[AREA_W-1:0];
        quo     <= {quo[QUOT_W-2:0], dbit};
      end
      S_ZCMP: begin
        if (z_pass) begin
          cnt <= cnt + 17'd1;
        end
      end
      S_ADV: begin
        if (px == maxx) begin
          px       <= minx;
          py       <= py + 14'sd1;
          row_base <= row_base + AW'(weff);
          r0 <= r0 + dy0;
          r1 <= r1 + dy1;
          r2 <= r2 + dy2;
          c0 <= r0 + dy0;
          c1 <= r1 + dy1;
          c2 <= r2 + dy2;
        end else begin
          px <= px + 14'sd1;
          c0 <= c0 + dx0;
          c1 <= c1 + dx1;
          c2 <= c2 + dx2;
        end
      end
      S_ADDR2: begin
        addr <= addr_wide[AW-1:0];
      end
      S_RD2: begin
        res_color <= col_rdata;
        res_depth <= dep_rdata;
      end
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (action == ACT_DRAW) begin
              state <= S_SETUP;
            end else if (action == ACT_READ || action == ACT_WRITE) begin
              state <= S_ADDR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SETUP: begin
          if (step == 4'd0 && box_empty) begin
            state <= S_DONE;
          end else if (step == 4'd9) begin
            state <= (area == '0) ? S_DONE : S_PIX;
          end
        end
        S_PIX: begin
          state <= covered ? S_Z : S_ADV;
        end
        S_Z: begin
          if (step == 4'd3) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == 5'(QUOT_W - 1)) begin
            state <= S_ZCMP;
          end
        end
        S_ZCMP: begin
          state <= S_ADV;
        end
        S_ADV: begin
          state <= (px == maxx && py == maxy) ? S_DONE : S_PIX;
        end
        S_ADDR: begin
          state <= rw_ok ? S_ADDR2 : S_DONE;
        end
        S_ADDR2: begin
          state <= S_RD;
        end
        S_RD: begin
          state <= (act == ACT_READ) ? S_RD2 : S_DONE;
        end
        S_RD2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      pixels_written <= cnt;
      read_color     <= res_color;
      read_depth     <= res_depth;
    end
  end

  // Checks on the sequencer and the depth test.
  `include "halfspace_triangle_raster_zbuf_unit_defines.svh"

  `HTRZ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted twice")
  `HTRZ_ASSERT_SAME(a_no_write_idle, state == S_IDLE, !ram_we, "store written while idle")
  `HTRZ_ASSERT_SAME(a_depth_nearer, state == S_ZCMP && ram_we, zsat < dep_rdata, "bad depth write")

endmodule

`default_nettype wire

/* src/htrz_ram.sv */
// ---------------------------------------------------------------------------
// htrz_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module htrz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/htrz_mul.sv */
// ---------------------------------------------------------------------------
// htrz_mul
// Shared signed multiplier with a registered product, one result per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module htrz_mul (
  input  wire logic            clk,
  input  wire htrz_pkg::mul_a_t a,
  input  wire htrz_pkg::mul_b_t b,
  output htrz_pkg::mul_p_t      p
);
  import htrz_pkg::*;

  // The product of the operands issued in one cycle is valid in the next.
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

`default_nettype wire
